[rtl/core/rhfs_pkg.sv]
// shared types, constants and helpers for the rainbow hsb fade sequencer
package rhfs_pkg;

  localparam int DEF_COUNT_BITS    = 16;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int LERP_W     = 16;
  localparam int SEG_W      = 4;
  localparam int PAL_SIZE   = 9;
  localparam int DIV_RADIX  = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SEG_W-1:0] SEG_RED    = 4'd0;
  localparam logic [SEG_W-1:0] SEG_ORANGE = 4'd1;
  localparam logic [SEG_W-1:0] SEG_YELLOW = 4'd2;
  localparam logic [SEG_W-1:0] SEG_GREEN  = 4'd3;
  localparam logic [SEG_W-1:0] SEG_BLUE   = 4'd4;
  localparam logic [SEG_W-1:0] SEG_INDIGO = 4'd5;
  localparam logic [SEG_W-1:0] SEG_VIOLET = 4'd6;
  localparam logic [SEG_W-1:0] SEG_WHITE  = 4'd7;
  localparam logic [SEG_W-1:0] SEG_BLACK  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_LERP_TICKS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_WHITE_BLACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MODE    = 2'd2;

  localparam logic [LERP_W-1:0] RST_LERP_TICKS      = 16'd1000;
  localparam logic              RST_USE_WHITE_BLACK = 1'b1;
  localparam logic              RST_REVERSE_MODE    = 1'b0;

  localparam logic [7:0] DIV_BY_255 = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_STORE,
    S_HUE,
    S_OUT
  } state_t;

  // interpolation of h, s, v, then the sector products p, s*rem, q, s*(1-rem), t
  typedef enum logic [2:0] {
    OP_IH,
    OP_IS,
    OP_IV,
    OP_P,
    OP_A,
    OP_Q,
    OP_B,
    OP_T
  } op_t;

  typedef struct packed {
    logic start;
    logic setup;
    logic mul;
    logic div_step;
    logic store;
    logic hue;
    logic finish;
    op_t  op;
  } rhfs_cmd_t;

  typedef struct packed {
    logic div_done;
  } rhfs_stat_t;

  function automatic logic [SEG_W-1:0] next_segment(input logic [SEG_W-1:0] s,
                                                    input logic wb,
                                                    input logic rev);
    logic [SEG_W-1:0] n;
    if (!rev) begin
      if (s <= SEG_INDIGO) n = s + SEG_W'(1);
      else if (s == SEG_VIOLET) n = wb ? SEG_WHITE : SEG_RED;
      else if (s == SEG_WHITE) n = SEG_BLACK;
      else n = SEG_RED;
    end else begin
      if (s >= SEG_ORANGE && s <= SEG_VIOLET) n = s - SEG_W'(1);
      else if (s == SEG_RED) n = wb ? SEG_WHITE : SEG_VIOLET;
      else if (s == SEG_WHITE) n = SEG_BLACK;
      else n = SEG_VIOLET;
    end
    return n;
  endfunction

endpackage

[rtl/core/rainbow_hsb_fade_sequencer.sv]
// top level: configuration registers, sequencer and datapath
// Each request is one time tick and yields one rgb colour plus the segment it belongs to.
// One request is worked at a time through eight multiply-and-divide passes on a single
// shared multiplier and a radix-16 restoring divider: three for the hue, saturation and
// brightness fades and five for the sector products of the hsb to rgb conversion. A
// finished result waits in the output step while the previous result has not been taken; a
// new request may be accepted while the previous result still waits on the output.
module rainbow_hsb_fade_sequencer import rhfs_pkg::*; #(
  parameter int COUNT_BITS    = DEF_COUNT_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [SEG_W-1:0]     out_segment,
  output logic                 out_segment_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LERP_W-1:0]    cfg_wdata
);

  logic [LERP_W-1:0] lerp_ticks_r;
  logic              use_white_black_r;
  logic              reverse_mode_r;

  rhfs_cmd_t  cmd;
  rhfs_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lerp_ticks_r      <= RST_LERP_TICKS;
      use_white_black_r <= RST_USE_WHITE_BLACK;
      reverse_mode_r    <= RST_REVERSE_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LERP_TICKS:      lerp_ticks_r      <= cfg_wdata;
        CFG_USE_WHITE_BLACK: use_white_black_r <= cfg_wdata[0];
        CFG_REVERSE_MODE:    reverse_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rhfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhfs_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_restart      (in_restart),
    .lerp_ticks      (lerp_ticks_r),
    .use_white_black (use_white_black_r),
    .reverse_mode    (reverse_mode_r),
    .red             (out_red),
    .green           (out_green),
    .blue            (out_blue),
    .segment         (out_segment),
    .segment_end     (out_segment_end)
  );

endmodule

[rtl/core/rhfs_ctrl.sv]
// sequencing state machine: request handshake, op order, divider wait, result register
module rhfs_ctrl import rhfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rhfs_stat_t stat,
  output rhfs_cmd_t  cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_IH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        op_nxt    = OP_IH;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        unique case (op_r)
          OP_IH: op_nxt = OP_IS;
          OP_IS: op_nxt = OP_IV;
          OP_IV: op_nxt = OP_P;
          OP_P:  op_nxt = OP_A;
          OP_A:  op_nxt = OP_Q;
          OP_Q:  op_nxt = OP_B;
          OP_B:  op_nxt = OP_T;
          OP_T:  op_nxt = OP_IH;
          default: op_nxt = OP_IH;
        endcase
        if (op_r == OP_IV) state_nxt = S_HUE;
        else if (op_r == OP_T) state_nxt = S_OUT;
        else state_nxt = S_MUL;
      end
      S_HUE: begin
        cmd.hue   = 1'b1;
        state_nxt = S_MUL;
      end
      S_OUT: begin
        // wait until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SETUP))
    else $error("accepted request did not enter setup");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result shown outside the output step");

  a_last_op_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE && op_r == OP_T) |=> (state_r == S_OUT && op_r == OP_IH))
    else $error("op sequence did not close after the last product");

endmodule

[rtl/core/rhfs_datapath.sv]
// segment state, hsb endpoints, shared multiplier and radix-16 divider, hsb to rgb
module rhfs_datapath import rhfs_pkg::*; #(
  parameter int COUNT_BITS    = DEF_COUNT_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rhfs_cmd_t         cmd,
  output rhfs_stat_t        stat,
  input  logic              in_restart,
  input  logic [LERP_W-1:0] lerp_ticks,
  input  logic              use_white_black,
  input  logic              reverse_mode,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [SEG_W-1:0]  segment,
  output logic              segment_end
);

  localparam int HW  = 8 + FRACTION_BITS;
  localparam int TB  = (COUNT_BITS < LERP_W) ? COUNT_BITS : LERP_W;
  localparam int XW  = ((COUNT_BITS > LERP_W) ? COUNT_BITS : LERP_W) + 1;
  localparam int DW  = HW + TB;
  localparam int DWP = ((DW + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
  localparam int DIV_CYCLES = DWP / DIV_RADIX;
  localparam int DCW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int PW  = 2 * HW;
  localparam int XHW = HW + 3;

  localparam logic [HW-1:0] FULL = HW'(64'd255 << FRACTION_BITS);

  // hue, saturation, brightness of each palette colour, rounded to nearest
  localparam logic [HW-1:0] HSB_TAB [PAL_SIZE][3] = '{
    '{HW'(0),
      HW'(((64'd65025 << FRACTION_BITS) + 64'd127) / 64'd255),
      HW'(64'd255 << FRACTION_BITS)},
    '{HW'(((64'd32385 << FRACTION_BITS) + 64'd765) / 64'd1530),
      HW'(((64'd65025 << FRACTION_BITS) + 64'd127) / 64'd255),
      HW'(64'd255 << FRACTION_BITS)},
    '{HW'(((64'd65025 << FRACTION_BITS) + 64'd765) / 64'd1530),
      HW'(((64'd65025 << FRACTION_BITS) + 64'd127) / 64'd255),
      HW'(64'd255 << FRACTION_BITS)},
    '{HW'(((64'd130050 << FRACTION_BITS) + 64'd765) / 64'd1530),
      HW'(((64'd65025 << FRACTION_BITS) + 64'd127) / 64'd255),
      HW'(64'd255 << FRACTION_BITS)},
    '{HW'(((64'd260100 << FRACTION_BITS) + 64'd765) / 64'd1530),
      HW'(((64'd65025 << FRACTION_BITS) + 64'd127) / 64'd255),
      HW'(64'd255 << FRACTION_BITS)},
    '{HW'(((64'd151725 << FRACTION_BITS) + 64'd390) / 64'd780),
      HW'(((64'd33150 << FRACTION_BITS) + 64'd65) / 64'd130),
      HW'(64'd130 << FRACTION_BITS)},
    '{HW'(((64'd137700 << FRACTION_BITS) + 64'd324) / 64'd648),
      HW'(((64'd27540 << FRACTION_BITS) + 64'd119) / 64'd238),
      HW'(64'd238 << FRACTION_BITS)},
    '{HW'(0), HW'(0), HW'(64'd255 << FRACTION_BITS)},
    '{HW'(0), HW'(0), HW'(0)}
  };

  localparam logic [XHW-1:0] FULL_MUL [6] = '{
    XHW'(0),
    XHW'(64'd255 << FRACTION_BITS),
    XHW'(64'd510 << FRACTION_BITS),
    XHW'(64'd765 << FRACTION_BITS),
    XHW'(64'd1020 << FRACTION_BITS),
    XHW'(64'd1275 << FRACTION_BITS)
  };

  // tick state
  logic [SEG_W-1:0]      seg_r;
  logic [COUNT_BITS-1:0] elapsed_r;
  logic                  restart_r;

  // per-tick values
  logic [SEG_W-1:0] seg_cur_r, nxt_r;
  logic [TB-1:0]    len_r, tick_r;
  logic             done_r;
  logic [HW-1:0]    base_r [3];
  logic [HW-1:0]    diff_r [3];
  logic [2:0]       up_r;
  logic [HW-1:0]    cur_r  [3];

  // conversion values
  logic [2:0]    sector_r;
  logic [HW-1:0] hrem_r, p_r, sa_r, q_r, sb_r, tt_r;

  // divider
  logic [DWP-1:0] qd_r, qd_w;
  logic [TB-1:0]  rm_r, rm_w, dvs_r;
  logic [TB:0]    rm_sh;
  logic [DCW-1:0] dcnt_r;

  logic [7:0]       red_r, green_r, blue_r;
  logic [SEG_W-1:0] segment_r;
  logic             segment_end_r;

  // setup signals
  logic [SEG_W-1:0]      seg_eff, seg_lut, seg_nxt;
  logic [COUNT_BITS-1:0] ela_eff;
  logic [LERP_W-1:0]     len_one;
  logic [XW-1:0]         len_x, cmax_x, len_c_x, t_x, t_c_x;

  // multiply signals
  logic [HW-1:0]  mul_a, mul_b;
  logic [TB-1:0]  dvs;
  logic           conv;
  logic [PW-1:0]  prod;
  logic [DWP-1:0] dividend;
  logic [HW-1:0]  quo;

  // hue sector signals
  logic [HW-1:0]  hm;
  logic [XHW-1:0] hx;
  logic [2:0]     sec;

  logic [HW-1:0] ch_r, ch_g, ch_b;

  function automatic logic [7:0] round8(input logic [HW-1:0] x);
    logic [HW:0] y;
    y = {1'b0, x} + ((HW+1)'(1) << (FRACTION_BITS - 1));
    if (y[HW:FRACTION_BITS] > 9'd255) return 8'd255;
    return y[FRACTION_BITS+7:FRACTION_BITS];
  endfunction

  always_comb begin
    seg_eff = restart_r ? (reverse_mode ? SEG_VIOLET : SEG_RED) : seg_r;
    ela_eff = restart_r ? '0 : elapsed_r;
    seg_lut = (seg_eff > SEG_BLACK) ? SEG_BLACK : seg_eff;
    seg_nxt = next_segment(seg_eff, use_white_black, reverse_mode);
    len_one = (lerp_ticks == '0) ? LERP_W'(1) : lerp_ticks;
    len_x   = XW'(len_one);
    cmax_x  = (XW'(1) << COUNT_BITS) - XW'(1);
    len_c_x = (len_x > cmax_x) ? cmax_x : len_x;
    t_x     = XW'(ela_eff) + XW'(1);
    t_c_x   = (t_x > len_c_x) ? len_c_x : t_x;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dvs   = TB'(DIV_BY_255);
    conv  = 1'b1;
    unique case (cmd.op)
      OP_IH: begin
        mul_a = diff_r[0]; mul_b = HW'(tick_r); dvs = len_r; conv = 1'b0;
      end
      OP_IS: begin
        mul_a = diff_r[1]; mul_b = HW'(tick_r); dvs = len_r; conv = 1'b0;
      end
      OP_IV: begin
        mul_a = diff_r[2]; mul_b = HW'(tick_r); dvs = len_r; conv = 1'b0;
      end
      OP_P: begin
        mul_a = cur_r[2]; mul_b = FULL - cur_r[1];
      end
      OP_A: begin
        mul_a = cur_r[1]; mul_b = hrem_r;
      end
      OP_Q: begin
        mul_a = cur_r[2]; mul_b = FULL - sa_r;
      end
      OP_B: begin
        mul_a = cur_r[1]; mul_b = FULL - hrem_r;
      end
      OP_T: begin
        mul_a = cur_r[2]; mul_b = FULL - sb_r;
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
    // division by 255 << F is a shift and then a division by 255
    dividend = conv ? DWP'(prod >> FRACTION_BITS) : DWP'(prod);
  end

  // four restoring steps per cycle
  always_comb begin
    rm_w  = rm_r;
    qd_w  = qd_r;
    rm_sh = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      rm_sh = {rm_w, qd_w[DWP-1]};
      qd_w  = {qd_w[DWP-2:0], 1'b0};
      if (rm_sh >= {1'b0, dvs_r}) begin
        rm_sh   = rm_sh - {1'b0, dvs_r};
        qd_w[0] = 1'b1;
      end
      rm_w = rm_sh[TB-1:0];
    end
  end

  assign stat.div_done = cmd.div_step && (dcnt_r == DCW'(DIV_CYCLES - 1));
  assign quo = qd_r[HW-1:0];

  always_comb begin
    hm = (cur_r[0] >= FULL) ? cur_r[0] - FULL : cur_r[0];
    hx = (XHW'(hm) << 2) + (XHW'(hm) << 1);
    priority if (hx >= FULL_MUL[5]) sec = 3'd5;
    else if (hx >= FULL_MUL[4]) sec = 3'd4;
    else if (hx >= FULL_MUL[3]) sec = 3'd3;
    else if (hx >= FULL_MUL[2]) sec = 3'd2;
    else if (hx >= FULL_MUL[1]) sec = 3'd1;
    else sec = 3'd0;
  end

  always_comb begin
    unique case (sector_r)
      3'd1: begin ch_r = q_r;      ch_g = cur_r[2]; ch_b = p_r;      end
      3'd2: begin ch_r = p_r;      ch_g = cur_r[2]; ch_b = tt_r;     end
      3'd3: begin ch_r = p_r;      ch_g = q_r;      ch_b = cur_r[2]; end
      3'd4: begin ch_r = tt_r;     ch_g = p_r;      ch_b = cur_r[2]; end
      3'd5: begin ch_r = cur_r[2]; ch_g = p_r;      ch_b = q_r;      end
      default: begin ch_r = cur_r[2]; ch_g = tt_r;  ch_b = p_r;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= SEG_RED;
      elapsed_r <= '0;
    end else if (cmd.finish) begin
      seg_r     <= done_r ? nxt_r : seg_cur_r;
      elapsed_r <= done_r ? '0 : COUNT_BITS'(tick_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) restart_r <= in_restart;
    if (cmd.setup) begin
      seg_cur_r <= seg_eff;
      nxt_r     <= seg_nxt;
      len_r     <= TB'(len_c_x);
      tick_r    <= TB'(t_c_x);
      done_r    <= (t_c_x == len_c_x);
      for (int c = 0; c < 3; c++) begin
        base_r[c] <= HSB_TAB[seg_lut][c];
        up_r[c]   <= HSB_TAB[seg_nxt][c] >= HSB_TAB[seg_lut][c];
        diff_r[c] <= (HSB_TAB[seg_nxt][c] >= HSB_TAB[seg_lut][c])
                   ? HSB_TAB[seg_nxt][c] - HSB_TAB[seg_lut][c]
                   : HSB_TAB[seg_lut][c] - HSB_TAB[seg_nxt][c];
      end
    end
    if (cmd.mul) begin
      qd_r   <= dividend;
      rm_r   <= '0;
      dvs_r  <= dvs;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      qd_r   <= qd_w;
      rm_r   <= rm_w;
      dcnt_r <= dcnt_r + DCW'(1);
    end
    if (cmd.store) begin
      unique case (cmd.op)
        OP_IH: cur_r[0] <= up_r[0] ? base_r[0] + quo : base_r[0] - quo;
        OP_IS: cur_r[1] <= up_r[1] ? base_r[1] + quo : base_r[1] - quo;
        OP_IV: cur_r[2] <= up_r[2] ? base_r[2] + quo : base_r[2] - quo;
        OP_P:  p_r  <= quo;
        OP_A:  sa_r <= quo;
        OP_Q:  q_r  <= quo;
        OP_B:  sb_r <= quo;
        OP_T:  tt_r <= quo;
        default: p_r <= quo;
      endcase
    end
    if (cmd.hue) begin
      sector_r <= sec;
      hrem_r   <= HW'(hx - FULL_MUL[sec]);
      if (cur_r[1] > FULL) cur_r[1] <= FULL;
      if (cur_r[2] > FULL) cur_r[2] <= FULL;
    end
    if (cmd.finish) begin
      red_r         <= round8(ch_r);
      green_r       <= round8(ch_g);
      blue_r        <= round8(ch_b);
      segment_r     <= seg_cur_r;
      segment_end_r <= done_r;
    end
  end

  assign red         = red_r;
  assign green       = green_r;
  assign blue        = blue_r;
  assign segment     = segment_r;
  assign segment_end = segment_end_r;

  a_elapsed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (XW'(elapsed_r) < XW'(len_r)))
    else $error("tick count left at or past the segment length");

  a_segment_valid: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= SEG_BLACK)
    else $error("segment index outside the palette");

endmodule
